FILE: design/bma_pkg.sv
// Shared types and codes for the batch message assembly block.
// Used by bma_event_logic and batch_message_assembly_fsm; depends on nothing.
`default_nettype none

package bma_pkg;

   // Field widths
   localparam int OP_W     = 3;
   localparam int SLOT_W   = 5;
   localparam int COUNT_W  = 6;
   localparam int MASK_W   = 32;
   localparam int STATUS_W = 2;
   localparam int PHASE_W  = 3;
   localparam int EXP_W    = 5;

   // Default number of message slots
   localparam int NUM_SLOTS_DEF = 32;

   // Event codes
   localparam logic [OP_W-1:0] OP_BEGIN = 3'd0;
   localparam logic [OP_W-1:0] OP_END   = 3'd1;
   localparam logic [OP_W-1:0] OP_BODY  = 3'd2;
   localparam logic [OP_W-1:0] OP_ALL   = 3'd3;
   localparam logic [OP_W-1:0] OP_START = 3'd4;
   localparam logic [OP_W-1:0] OP_DONE  = 3'd5;
   localparam logic [OP_W-1:0] OP_RESET = 3'd6;
   localparam logic [OP_W-1:0] OP_ERROR = 3'd7;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_WAIT_END = 3'd1;
   localparam logic [PHASE_W-1:0] PH_COLLECT  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_READY    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PROC     = 3'd4;
   localparam logic [PHASE_W-1:0] PH_COMPLETE = 3'd5;
   localparam logic [PHASE_W-1:0] PH_ERROR    = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd3;

   // Batch context carried between events
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [EXP_W-1:0]   expected;
      logic [COUNT_W-1:0] collected;
      logic [MASK_W-1:0]  members;
      logic [MASK_W-1:0]  occupied;
   } ctx_type;

endpackage

`default_nettype wire

FILE: design/bma_event_logic.sv
// Next-context and status logic for one batch event.
// Depends on bma_pkg for codes and the context struct.
`default_nettype none

module bma_event_logic #(
   parameter int NUM_SLOTS = bma_pkg::NUM_SLOTS_DEF
) (
   input  wire bma_pkg::ctx_type                ctx,
   input  wire logic [bma_pkg::OP_W-1:0]        op,
   input  wire logic [bma_pkg::SLOT_W-1:0]      slot,
   input  wire logic [bma_pkg::COUNT_W-1:0]     msg_total,
   input  wire logic [bma_pkg::MASK_W-1:0]      member_mask,
   output bma_pkg::ctx_type                     ctx_nxt,
   output logic [bma_pkg::STATUS_W-1:0]         status
);

   // Width that holds both the slot count field and NUM_SLOTS
   localparam int CLAMP_W = ($clog2(NUM_SLOTS + 1) > bma_pkg::COUNT_W) ?
                            $clog2(NUM_SLOTS + 1) : bma_pkg::COUNT_W;
   localparam logic [CLAMP_W-1:0] MAX_SLOTS = CLAMP_W'(NUM_SLOTS);
   localparam logic [CLAMP_W-1:0] MIN_SLOTS = CLAMP_W'(2);
   localparam logic [CLAMP_W-1:0] EXP_MAX   = CLAMP_W'((1 << bma_pkg::EXP_W) - 1);

   logic [CLAMP_W-1:0]             count_ext;
   logic [CLAMP_W-1:0]             count_clamped;
   logic [CLAMP_W-1:0]             body_total;
   logic [bma_pkg::EXP_W-1:0]      expected_val;
   logic                           slot_ok;
   logic [bma_pkg::MASK_W-1:0]     slot_bit;
   logic                           is_member;
   logic                           is_dup;
   logic [bma_pkg::COUNT_W-1:0]    coll_inc;
   logic                           all_in;

   // Clamp the slot count and derive the expected body count
   always_comb begin
      count_ext     = CLAMP_W'(msg_total);
      count_clamped = (count_ext < MIN_SLOTS) ? MIN_SLOTS :
                      (count_ext > MAX_SLOTS) ? MAX_SLOTS : count_ext;
      body_total    = count_clamped - MIN_SLOTS;
      expected_val  = (body_total > EXP_MAX) ? bma_pkg::EXP_W'(EXP_MAX) :
                                               bma_pkg::EXP_W'(body_total);
   end

   // Slot checks against the stored masks
   assign slot_ok   = CLAMP_W'(slot) < MAX_SLOTS;
   assign slot_bit  = slot_ok ? (bma_pkg::MASK_W'(1) << slot) : '0;
   assign is_member = slot_ok && ctx.members[slot];
   assign is_dup    = ctx.occupied[slot];
   assign coll_inc  = ctx.collected + bma_pkg::COUNT_W'(1);
   assign all_in    = coll_inc >= bma_pkg::COUNT_W'(ctx.expected);

   // Apply the transition table
   always_comb begin
      ctx_nxt = ctx;
      status  = bma_pkg::ST_OK;
      case (op)
         bma_pkg::OP_BEGIN: begin
            if (ctx.phase == bma_pkg::PH_IDLE) begin
               ctx_nxt.phase     = bma_pkg::PH_WAIT_END;
               ctx_nxt.expected  = expected_val;
               ctx_nxt.collected = '0;
               ctx_nxt.members   = member_mask;
               ctx_nxt.occupied  = slot_bit;
            end else begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_INVALID;
            end
         end
         bma_pkg::OP_END: begin
            if (ctx.phase == bma_pkg::PH_WAIT_END) begin
               ctx_nxt.phase    = bma_pkg::PH_COLLECT;
               ctx_nxt.occupied = ctx.occupied | slot_bit;
            end else begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_INVALID;
            end
         end
         bma_pkg::OP_BODY: begin
            if (!is_member) begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_NOT_MEMBER;
            end else if (is_dup) begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_DUPLICATE;
            end else begin
               ctx_nxt.occupied  = ctx.occupied | slot_bit;
               ctx_nxt.collected = coll_inc;
               // Last body fires all-collected, legal only while collecting
               if (all_in) begin
                  if (ctx.phase == bma_pkg::PH_COLLECT) begin
                     ctx_nxt.phase = bma_pkg::PH_READY;
                  end else begin
                     ctx_nxt.phase = bma_pkg::PH_ERROR;
                     status        = bma_pkg::ST_INVALID;
                  end
               end
            end
         end
         bma_pkg::OP_ALL: begin
            if (ctx.phase == bma_pkg::PH_COLLECT) begin
               ctx_nxt.phase = bma_pkg::PH_READY;
            end else begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_INVALID;
            end
         end
         bma_pkg::OP_START: begin
            if (ctx.phase == bma_pkg::PH_READY) begin
               ctx_nxt.phase = bma_pkg::PH_PROC;
            end else begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_INVALID;
            end
         end
         bma_pkg::OP_DONE: begin
            if (ctx.phase == bma_pkg::PH_PROC) begin
               ctx_nxt.phase = bma_pkg::PH_COMPLETE;
            end else begin
               ctx_nxt.phase = bma_pkg::PH_ERROR;
               status        = bma_pkg::ST_INVALID;
            end
         end
         bma_pkg::OP_RESET: begin
            ctx_nxt       = '0;
            ctx_nxt.phase = bma_pkg::PH_IDLE;
         end
         bma_pkg::OP_ERROR: begin
            ctx_nxt.phase = bma_pkg::PH_ERROR;
         end
         default: begin
            ctx_nxt = ctx;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/batch_message_assembly_fsm.sv
// Batch message assembly tracker: takes one event per cycle on the req_
// channel while rsp_ does not stall, and returns exactly one result per
// event on the rsp_ channel, in order. An event is held in an input
// register after its transfer; once the result register is empty or
// taken, the transition logic updates the batch context and loads the
// result register that drives rsp_. Throughput is one event per cycle
// while rsp_ does not stall, set by the context register loop, which
// closes through bma_event_logic. A stalled result holds the result
// register, then the input register, and req_ready drops once both are
// full. Depends on bma_pkg and bma_event_logic.
`default_nettype none

module batch_message_assembly_fsm #(
   parameter int NUM_SLOTS = bma_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Event channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bma_pkg::OP_W-1:0]         req_op,
   input  wire logic [bma_pkg::SLOT_W-1:0]       req_slot,
   input  wire logic [bma_pkg::COUNT_W-1:0]      req_msg_total,
   input  wire logic [bma_pkg::MASK_W-1:0]       req_member_mask,
   // Result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [bma_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bma_pkg::PHASE_W-1:0]           rsp_next_phase,
   output logic [bma_pkg::COUNT_W-1:0]           rsp_collected_count,
   output logic [bma_pkg::EXP_W-1:0]             rsp_expected_count,
   output logic                                  rsp_active
);

   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic [bma_pkg::OP_W-1:0]         s1_op_ff;
   logic [bma_pkg::SLOT_W-1:0]       s1_slot_ff;
   logic [bma_pkg::COUNT_W-1:0]      s1_count_ff;
   logic [bma_pkg::MASK_W-1:0]       s1_mask_ff;

   bma_pkg::ctx_type                 ctx_ff;
   bma_pkg::ctx_type                 ctx_in;
   logic [bma_pkg::STATUS_W-1:0]     status_in;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [bma_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [bma_pkg::PHASE_W-1:0]      rsp_state_ff;
   logic [bma_pkg::COUNT_W-1:0]      rsp_coll_ff;
   logic [bma_pkg::EXP_W-1:0]        rsp_exp_ff;
   logic                             rsp_active_ff;
   logic                             rsp_active_in;

   logic                             out_load;
   logic                             s1_take;

   // Handshake: result register frees when empty or taken
   assign out_load     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || out_load;
   assign s1_take      = req_valid && req_ready;
   assign s1_valid_in  = s1_take || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   // Transition logic for the event in the input register
   bma_event_logic #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_event (
      .ctx         (ctx_ff),
      .op          (s1_op_ff),
      .slot        (s1_slot_ff),
      .msg_total   (s1_count_ff),
      .member_mask (s1_mask_ff),
      .ctx_nxt     (ctx_in),
      .status      (status_in)
   );

   assign rsp_active_in = ctx_in.phase inside {bma_pkg::PH_WAIT_END, bma_pkg::PH_COLLECT,
                                               bma_pkg::PH_READY, bma_pkg::PH_PROC};

   // Control and context registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_load) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   // Capture the event payload on a transfer
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_op_ff    <= req_op;
         s1_slot_ff  <= req_slot;
         s1_count_ff <= req_msg_total;
         s1_mask_ff  <= req_member_mask;
      end
   end

   // Load the result register as the context advances
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= status_in;
         rsp_state_ff  <= ctx_in.phase;
         rsp_coll_ff   <= ctx_in.collected;
         rsp_exp_ff    <= ctx_in.expected;
         rsp_active_ff <= rsp_active_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_next_phase      = rsp_state_ff;
   assign rsp_collected_count = rsp_coll_ff;
   assign rsp_expected_count  = rsp_exp_ff;
   assign rsp_active          = rsp_active_ff;

   // Any failure status lands in the error state
   a_fail_is_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bma_pkg::ST_OK) |->
         (rsp_next_phase == bma_pkg::PH_ERROR))
      else $error("failure status without error state");

   // A reset event returns a cleared idle context
   a_reset_event: assert property (@(posedge clock) disable iff (reset)
      (out_load && s1_op_ff == bma_pkg::OP_RESET) |=>
         (rsp_status == bma_pkg::ST_OK && rsp_next_phase == bma_pkg::PH_IDLE &&
          rsp_collected_count == '0 && rsp_expected_count == '0 && !rsp_active))
      else $error("reset event did not clear the context");

   // Context only moves when a result is loaded
   a_ctx_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(ctx_ff))
      else $error("context changed without a result");

   // A held event is not overwritten while the result side stalls
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> (s1_valid_ff && $stable(s1_op_ff) &&
                                      $stable(s1_slot_ff)))
      else $error("pending event lost");

endmodule

`default_nettype wire

FILE: tb/bma_batch_checker.sv
// Batch assembly checker: watches the event and result channels of
// batch_message_assembly_fsm, predicts each result and compares it.
// Depends on bma_pkg for widths and event, phase and status codes.

module bma_batch_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [bma_pkg::OP_W-1:0]     req_op,
   input  wire logic [bma_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [bma_pkg::COUNT_W-1:0]  req_msg_total,
   input  wire logic [bma_pkg::MASK_W-1:0]   req_member_mask,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [bma_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [bma_pkg::PHASE_W-1:0]  rsp_next_phase,
   input  wire logic [bma_pkg::COUNT_W-1:0]  rsp_collected_count,
   input  wire logic [bma_pkg::EXP_W-1:0]    rsp_expected_count,
   input  wire logic                         rsp_active,
   output int                                fail_count,
   output int                                pending
);

   localparam int SLOTS = bma_pkg::NUM_SLOTS_DEF;

   typedef struct packed {
      logic [bma_pkg::STATUS_W-1:0] status;
      logic [bma_pkg::PHASE_W-1:0]  next_phase;
      logic [bma_pkg::COUNT_W-1:0]  collected;
      logic [bma_pkg::EXP_W-1:0]    expected;
      logic                         active;
   } batch_outcome_type;

   // Outcomes predicted for accepted events, oldest first
   batch_outcome_type outcome_q[$];
   int mismatches = 0;

   // Predicted batch context
   logic [bma_pkg::PHASE_W-1:0] batch_phase;
   logic [bma_pkg::EXP_W-1:0]   body_target;
   logic [bma_pkg::COUNT_W-1:0] body_seen;
   logic [bma_pkg::MASK_W-1:0]  members;
   logic [bma_pkg::MASK_W-1:0]  occupied;

   task automatic clear_batch();
      body_target = '0;
      body_seen   = '0;
      members     = '0;
      occupied    = '0;
   endtask

   // Advance the predicted context by one event and return its outcome
   task automatic apply_event(input logic [bma_pkg::OP_W-1:0] op,
                              input logic [bma_pkg::SLOT_W-1:0] slot,
                              input logic [bma_pkg::COUNT_W-1:0] cnt,
                              input logic [bma_pkg::MASK_W-1:0] mask,
                              output batch_outcome_type outcome);
      logic                         legal;
      logic [bma_pkg::STATUS_W-1:0] status;
      logic [bma_pkg::COUNT_W-1:0]  clamped;
      status = bma_pkg::ST_OK;
      case (op)
         bma_pkg::OP_BEGIN: legal = (batch_phase == bma_pkg::PH_IDLE);
         bma_pkg::OP_END:   legal = (batch_phase == bma_pkg::PH_WAIT_END);
         bma_pkg::OP_ALL:   legal = (batch_phase == bma_pkg::PH_COLLECT);
         bma_pkg::OP_START: legal = (batch_phase == bma_pkg::PH_READY);
         bma_pkg::OP_DONE:  legal = (batch_phase == bma_pkg::PH_PROC);
         default:           legal = 1'b1;
      endcase

      if (!legal) begin
         // No table entry: force error, keep the context
         batch_phase = bma_pkg::PH_ERROR;
         status      = bma_pkg::ST_INVALID;
      end else begin
         case (op)
            bma_pkg::OP_BEGIN: begin
               // Clamp slot count into 2..SLOTS
               if (cnt < 2)
                  clamped = bma_pkg::COUNT_W'(2);
               else if (cnt > SLOTS)
                  clamped = bma_pkg::COUNT_W'(SLOTS);
               else
                  clamped = cnt;
               clear_batch();
               body_target    = bma_pkg::EXP_W'(clamped - bma_pkg::COUNT_W'(2));
               members        = mask;
               occupied[slot] = 1'b1;
               batch_phase    = bma_pkg::PH_WAIT_END;
            end
            bma_pkg::OP_END: begin
               occupied[slot] = 1'b1;
               batch_phase    = bma_pkg::PH_COLLECT;
            end
            bma_pkg::OP_ALL:   batch_phase = bma_pkg::PH_READY;
            bma_pkg::OP_START: batch_phase = bma_pkg::PH_PROC;
            bma_pkg::OP_DONE:  batch_phase = bma_pkg::PH_COMPLETE;
            bma_pkg::OP_RESET: begin
               clear_batch();
               batch_phase = bma_pkg::PH_IDLE;
            end
            bma_pkg::OP_ERROR: batch_phase = bma_pkg::PH_ERROR;
            bma_pkg::OP_BODY: begin
               // Every 5-bit slot is below SLOTS, so only the mask decides membership
               if (!members[slot]) begin
                  batch_phase = bma_pkg::PH_ERROR;
                  status      = bma_pkg::ST_NOT_MEMBER;
               end else if (occupied[slot]) begin
                  batch_phase = bma_pkg::PH_ERROR;
                  status      = bma_pkg::ST_DUPLICATE;
               end else begin
                  occupied[slot] = 1'b1;
                  body_seen      = body_seen + bma_pkg::COUNT_W'(1);
                  // All collected fires; legal only while collecting
                  if (body_seen >= bma_pkg::COUNT_W'(body_target)) begin
                     if (batch_phase == bma_pkg::PH_COLLECT) begin
                        batch_phase = bma_pkg::PH_READY;
                     end else begin
                        batch_phase = bma_pkg::PH_ERROR;
                        status      = bma_pkg::ST_INVALID;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      outcome.status     = status;
      outcome.next_phase = batch_phase;
      outcome.collected  = body_seen;
      outcome.expected   = body_target;
      outcome.active     = batch_phase inside {bma_pkg::PH_WAIT_END, bma_pkg::PH_COLLECT,
                                               bma_pkg::PH_READY, bma_pkg::PH_PROC};
   endtask

   // Predict on each event transfer, compare on each result transfer
   always @(posedge clock) begin : track
      batch_outcome_type predicted;
      batch_outcome_type want;
      if (reset) begin
         clear_batch();
         batch_phase = bma_pkg::PH_IDLE;
         outcome_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            apply_event(req_op, req_slot, req_msg_total, req_member_mask, predicted);
            outcome_q.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("result with no event outstanding: status %0d, next_phase %0d",
                      rsp_status, rsp_next_phase);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_next_phase !== want.next_phase) begin
                  $error("next_phase: expected %0d, actual %0d", want.next_phase,
                         rsp_next_phase);
                  mismatches++;
               end
               if (rsp_collected_count !== want.collected) begin
                  $error("collected_count: expected %0d, actual %0d", want.collected,
                         rsp_collected_count);
                  mismatches++;
               end
               if (rsp_expected_count !== want.expected) begin
                  $error("expected_count: expected %0d, actual %0d", want.expected,
                         rsp_expected_count);
                  mismatches++;
               end
               if (rsp_active !== want.active) begin
                  $error("active: expected %0d, actual %0d", want.active, rsp_active);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= outcome_q.size();
   end

endmodule

FILE: tb/tb_top.sv
// Top of the batch assembly testbench: clock, reset, event stimulus and
// result-side stalls. Depends on bma_pkg, batch_message_assembly_fsm and bma_batch_checker.

module tb_top;

   localparam int ITEM_TARGET  = 1100;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [bma_pkg::OP_W-1:0]     req_op = '0;
   logic [bma_pkg::SLOT_W-1:0]   req_slot = '0;
   logic [bma_pkg::COUNT_W-1:0]  req_msg_total = '0;
   logic [bma_pkg::MASK_W-1:0]   req_member_mask = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [bma_pkg::STATUS_W-1:0] rsp_status;
   logic [bma_pkg::PHASE_W-1:0]  rsp_next_phase;
   logic [bma_pkg::COUNT_W-1:0]  rsp_collected_count;
   logic [bma_pkg::EXP_W-1:0]    rsp_expected_count;
   logic                         rsp_active;

   int fail_count;
   int pending;
   int cycle_count  = 0;
   int items_sent   = 0;
   int burst_left   = 0;
   bit hold_request = 1'b0;

   batch_message_assembly_fsm dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_slot            (req_slot),
      .req_msg_total       (req_msg_total),
      .req_member_mask     (req_member_mask),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_next_phase      (rsp_next_phase),
      .rsp_collected_count (rsp_collected_count),
      .rsp_expected_count  (rsp_expected_count),
      .rsp_active          (rsp_active)
   );

   bma_batch_checker batch_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_slot            (req_slot),
      .req_msg_total       (req_msg_total),
      .req_member_mask     (req_member_mask),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_next_phase      (rsp_next_phase),
      .rsp_collected_count (rsp_collected_count),
      .rsp_expected_count  (rsp_expected_count),
      .rsp_active          (rsp_active),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one event in bursts with random gaps; return after its transfer
   task automatic send_event(input logic [bma_pkg::OP_W-1:0] op, input logic [31:0] slot,
                             input logic [31:0] cnt, input logic [31:0] mask);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_slot        <= slot[bma_pkg::SLOT_W-1:0];
      req_msg_total   <= cnt[bma_pkg::COUNT_W-1:0];
      req_member_mask <= mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Result side: stall in segments of varying density, plus one long hold-off
   initial begin : receiver
      int  mode;
      int  len;
      bit  hold_done;
      logic ready_next;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(8, 64);
         repeat (len) begin
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 1) == 1);
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
            rsp_ready <= ready_next;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int          slots[32];
      int          body_q[$];
      int          n_body;
      int          end_pos;
      int          pick;
      int          tmp;
      int          k;
      int          n_noise;
      logic [4:0]  first_slot;
      logic [4:0]  last_slot;
      logic [4:0]  body_slot;
      logic [5:0]  cnt;
      logic [31:0] mask;
      while (reset) @(posedge clock);

      // Directed: illegal events, clamping, early and duplicate bodies
      send_event(bma_pkg::OP_BODY, 0, 0, 0);                // body while idle: not a member
      send_event(bma_pkg::OP_RESET, 0, 0, 0);
      send_event(bma_pkg::OP_END, 0, 0, 0);                 // end while idle: invalid
      send_event(bma_pkg::OP_ERROR, 0, 0, 0);               // error while in error
      send_event(bma_pkg::OP_RESET, 31, 63, 32'hFFFF_FFFF);
      send_event(bma_pkg::OP_BEGIN, 31, 0, 32'hFFFF_FFFF);  // slot count clamped up
      send_event(bma_pkg::OP_END, 0, 0, 0);
      send_event(bma_pkg::OP_ALL, 0, 0, 0);                 // nothing to collect
      send_event(bma_pkg::OP_START, 0, 0, 0);
      send_event(bma_pkg::OP_DONE, 0, 0, 0);
      send_event(bma_pkg::OP_DONE, 0, 0, 0);                // done while complete: invalid
      send_event(bma_pkg::OP_RESET, 0, 0, 0);
      send_event(bma_pkg::OP_BEGIN, 0, 63, 32'hFFFF_FFFF);  // slot count clamped down
      send_event(bma_pkg::OP_BODY, 5, 0, 0);                // body before end
      send_event(bma_pkg::OP_BODY, 5, 0, 0);                // duplicate
      send_event(bma_pkg::OP_RESET, 0, 0, 0);
      send_event(bma_pkg::OP_BEGIN, 1, 3, 32'h0000_00F0);
      send_event(bma_pkg::OP_BODY, 4, 0, 0);                // count reached outside collecting
      send_event(bma_pkg::OP_RESET, 0, 0, 0);
      send_event(bma_pkg::OP_BEGIN, 1, 4, 32'h8000_000F);
      send_event(bma_pkg::OP_END, 31, 0, 0);
      send_event(bma_pkg::OP_BODY, 0, 0, 0);
      send_event(bma_pkg::OP_BODY, 3, 0, 0);                // last body: ready
      send_event(bma_pkg::OP_BEGIN, 2, 2, 0);               // begin while ready: invalid
      send_event(bma_pkg::OP_RESET, 0, 0, 0);

      hold_request = 1'b1;

      // Random: mostly complete batches with random content, some noise
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 9))
               0:       cnt = 6'($urandom_range(0, 1));
               1:       cnt = 6'($urandom_range(33, 63));
               2, 3:    cnt = 6'($urandom_range(9, 32));
               default: cnt = 6'($urandom_range(2, 8));
            endcase
            n_body = (cnt < 2) ? 0 : (cnt > 32) ? 30 : cnt - 2;
            first_slot = 5'($urandom);
            last_slot  = 5'($urandom);

            // Pick distinct body slots away from the begin and end slots
            for (k = 0; k < 32; k++) slots[k] = k;
            for (k = 31; k > 0; k--) begin
               pick        = $urandom_range(0, k);
               tmp         = slots[k];
               slots[k]    = slots[pick];
               slots[pick] = tmp;
            end
            body_q.delete();
            mask = '0;
            for (k = 0; k < 32; k++) begin
               if (slots[k] != first_slot && slots[k] != last_slot &&
                   body_q.size() < n_body) begin
                  body_q.push_back(slots[k]);
                  mask[slots[k]] = 1'b1;
               end
            end
            mask |= ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & $urandom & $urandom);

            end_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_body) : 0;
            send_event(bma_pkg::OP_BEGIN, first_slot, cnt, mask);
            for (k = 0; k <= n_body; k++) begin
               if (k == end_pos)
                  send_event(bma_pkg::OP_END, last_slot, $urandom, $urandom);
               if (k < n_body) begin
                  body_slot = 5'(body_q[k]);
                  pick = $urandom_range(0, 99);
                  if (pick < 4) begin
                     // Repeat an occupied slot
                     body_slot = (k == 0 || pick < 2) ? first_slot :
                                 5'(body_q[$urandom_range(0, k - 1)]);
                  end else if (pick < 7 && mask != 32'hFFFF_FFFF) begin
                     // Pick a slot outside the batch
                     body_slot = 5'($urandom);
                     while (mask[body_slot]) body_slot = body_slot + 1'b1;
                  end
                  send_event(bma_pkg::OP_BODY, body_slot, $urandom, $urandom);
               end
            end
            if (n_body == 0 || $urandom_range(0, 9) == 0)
               send_event(bma_pkg::OP_ALL, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 9) != 0) begin
               send_event(bma_pkg::OP_START, $urandom, $urandom, $urandom);
               send_event(bma_pkg::OP_DONE, $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 4) == 0)
               send_event(bma_pkg::OP_ERROR, $urandom, $urandom, $urandom);
            send_event(bma_pkg::OP_RESET, $urandom, $urandom, $urandom);
         end else begin
            n_noise = $urandom_range(1, 4);
            repeat (n_noise)
               send_event(bma_pkg::OP_W'($urandom), $urandom, $urandom, $urandom);
            if ($urandom_range(0, 9) < 6)
               send_event(bma_pkg::OP_RESET, $urandom, $urandom, $urandom);
         end
      end
      req_valid <= 1'b0;

      // Drain: let the checker see the last transfer, then wait for all results
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
